// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared widths and limits for the lyric timestamp parser and its channels.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int TEXT_W   = 8;
    localparam int MILLIS_W = 23;

    // Largest total the parser can produce: 99 minutes, 99 seconds, 999 ms.
    localparam logic [MILLIS_W-1:0] MILLIS_MAX = MILLIS_W'(6039999);

endpackage

// ===== rtl/lts_if.sv =====
// ----------------------------------------------------------------------------
// lts_if
// Valid/ready channels for timestamp text bytes and parse results.
// ----------------------------------------------------------------------------
interface lts_text_if;
    import lts_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface lts_result_if;
    import lts_pkg::*;

    logic                valid;
    logic                ready;
    logic                parse_ok;
    logic [MILLIS_W-1:0] total_millis;

    modport source (output valid, output parse_ok, output total_millis, input ready);
    modport sink   (input valid, input parse_ok, input total_millis, output ready);
endinterface

// ===== rtl/lyric_timestamp_parser.sv =====
// ----------------------------------------------------------------------------
// lyric_timestamp_parser
// Parses "mm:ss[.fff]" lyric timestamps streamed one byte per beat and
// reports the time in milliseconds after the last byte.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                     Beat
//  text     in   text_byte[7:0], is_final    one character of the timestamp
//  result   out  parse_ok, total_millis[22:0] one per string, after its end
//
// The parser state updates at the byte's beat; a final byte snapshots the
// parsed fields into a holding register, and the millisecond total is
// formed between that register and the output register. A stall on
// result holds the output register and, once the holding register is
// full, stops text; else one byte is taken every cycle. Reset returns
// the parser to its leading whitespace phase.
// ----------------------------------------------------------------------------
module lyric_timestamp_parser (
    input logic          clk,
    input logic          rst_n,
    lts_text_if.sink     text,
    lts_result_if.source result
);
    import lts_pkg::*;

    localparam logic [3:0] PH_LEAD      = 4'd0;
    localparam logic [3:0] PH_MIN       = 4'd1;
    localparam logic [3:0] PH_MIN_WS    = 4'd2;
    localparam logic [3:0] PH_SEC_LEAD  = 4'd3;
    localparam logic [3:0] PH_SEC       = 4'd4;
    localparam logic [3:0] PH_SEC_WS    = 4'd5;
    localparam logic [3:0] PH_FRAC_LEAD = 4'd6;
    localparam logic [3:0] PH_FRAC      = 4'd7;
    localparam logic [3:0] PH_FRAC_WS   = 4'd8;
    localparam logic [3:0] PH_ERR       = 4'd9;

    typedef struct packed {
        logic        ok;
        logic        has_frac;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [13:0] fraction;
        logic [2:0]  frac_digits;
    } snap_t;

    // Parser state.
    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic [13:0] frac_reg, frac_next;

    // Holding register between the parser and the output stage.
    logic  snap_valid_reg, snap_valid_next;
    snap_t snap_reg, snap_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg;
    logic [MILLIS_W-1:0] out_millis_reg, out_millis_next;

    logic              text_acc;
    logic              out_free;
    logic              snap_move;
    logic [TEXT_W-1:0] c;
    logic [3:0]        d;
    logic              is_ws, is_digit, is_sep;

    logic [26:0]         frac_prod;
    logic [9:0]          ms;
    logic [MILLIS_W-1:0] min_ms, sec_ms;

    assign out_free  = !out_valid_reg || result.ready;
    assign snap_move = snap_valid_reg && out_free;
    assign text.ready = !snap_valid_reg || out_free;
    assign text_acc  = text.valid && text.ready;

    assign c = text.text_byte;
    assign d = c[3:0];

    always_comb
    begin
        is_ws    = c inside {8'h20, [8'h09:8'h0D]};
        is_digit = c inside {[8'h30:8'h39]};
        is_sep   = (c == 8'h3A) || (c == 8'h2E);
    end

    // One step of the character classifier; anything unexpected lands in
    // the error phase, which absorbs the rest of the string.
    always_comb
    begin
        phase_next = PH_ERR;
        count_next = count_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        frac_next  = frac_reg;
        case (phase_reg)
            PH_LEAD:
            begin
                if (is_ws)
                begin
                    phase_next = PH_LEAD;
                end
                else if (is_digit)
                begin
                    min_next   = 7'(d);
                    count_next = 3'd1;
                    phase_next = PH_MIN;
                end
            end
            PH_MIN:
            begin
                if (is_digit && count_reg < 3'd2)
                begin
                    min_next   = 7'(min_reg * 7'd10 + 7'(d));
                    count_next = count_reg + 3'd1;
                    phase_next = PH_MIN;
                end
                else if (is_ws)
                begin
                    phase_next = PH_MIN_WS;
                end
                else if (is_sep)
                begin
                    phase_next = PH_SEC_LEAD;
                end
            end
            PH_MIN_WS:
            begin
                if (is_ws)
                begin
                    phase_next = PH_MIN_WS;
                end
                else if (is_sep)
                begin
                    phase_next = PH_SEC_LEAD;
                end
            end
            PH_SEC_LEAD:
            begin
                if (is_ws)
                begin
                    phase_next = PH_SEC_LEAD;
                end
                else if (is_digit)
                begin
                    sec_next   = 7'(d);
                    count_next = 3'd1;
                    phase_next = PH_SEC;
                end
            end
            PH_SEC:
            begin
                if (is_digit && count_reg < 3'd2)
                begin
                    sec_next   = 7'(sec_reg * 7'd10 + 7'(d));
                    count_next = count_reg + 3'd1;
                    phase_next = PH_SEC;
                end
                else if (is_ws)
                begin
                    phase_next = PH_SEC_WS;
                end
                else if (is_sep)
                begin
                    phase_next = PH_FRAC_LEAD;
                end
            end
            PH_SEC_WS:
            begin
                if (is_ws)
                begin
                    phase_next = PH_SEC_WS;
                end
                else if (is_sep)
                begin
                    phase_next = PH_FRAC_LEAD;
                end
            end
            PH_FRAC_LEAD:
            begin
                if (is_ws)
                begin
                    phase_next = PH_FRAC_LEAD;
                end
                else if (is_digit)
                begin
                    frac_next  = 14'(d);
                    count_next = 3'd1;
                    phase_next = PH_FRAC;
                end
            end
            PH_FRAC:
            begin
                if (is_digit && count_reg < 3'd4)
                begin
                    frac_next  = 14'(frac_reg * 14'd10 + 14'(d));
                    count_next = count_reg + 3'd1;
                    phase_next = PH_FRAC;
                end
                else if (is_ws)
                begin
                    phase_next = PH_FRAC_WS;
                end
            end
            PH_FRAC_WS:
            begin
                if (is_ws)
                begin
                    phase_next = PH_FRAC_WS;
                end
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
    end

    always_comb
    begin
        snap_next.ok = (phase_next == PH_SEC) || (phase_next == PH_SEC_WS) ||
                       (phase_next == PH_FRAC) || (phase_next == PH_FRAC_WS);
        snap_next.has_frac    = (phase_next == PH_FRAC) || (phase_next == PH_FRAC_WS);
        snap_next.minutes     = min_next;
        snap_next.seconds     = sec_next;
        snap_next.fraction    = frac_next;
        snap_next.frac_digits = count_next;

        snap_valid_next = snap_valid_reg;
        if (text_acc && text.is_final)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            count_reg      <= 3'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (text_acc)
            begin
                if (text.is_final)
                begin
                    phase_reg <= PH_LEAD;
                    count_reg <= 3'd0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_acc)
        begin
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            frac_reg <= frac_next;
        end
        if (text_acc && text.is_final)
        begin
            snap_reg <= snap_next;
        end
    end

    // Fraction scaling; four digits divide by ten through a reciprocal
    // multiply that is exact for every value up to 9999.
    always_comb
    begin
        frac_prod = 27'(snap_reg.fraction) * 27'd6554;
        case (snap_reg.frac_digits)
            3'd1:    ms = 10'(snap_reg.fraction * 14'd100);
            3'd2:    ms = 10'(snap_reg.fraction * 14'd10);
            3'd3:    ms = 10'(snap_reg.fraction);
            3'd4:    ms = frac_prod[25:16];
            default: ms = 10'd0;
        endcase
        if (!snap_reg.has_frac)
        begin
            ms = 10'd0;
        end
        min_ms = MILLIS_W'(snap_reg.minutes) * MILLIS_W'(60000);
        sec_ms = MILLIS_W'(snap_reg.seconds) * MILLIS_W'(1000);
        out_millis_next = snap_reg.ok ? (min_ms + sec_ms + MILLIS_W'(ms)) : '0;

        out_valid_next = out_valid_reg;
        if (snap_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_move)
        begin
            out_ok_reg     <= snap_reg.ok;
            out_millis_reg <= out_millis_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.parse_ok     = out_ok_reg;
    assign result.total_millis = out_millis_reg;

endmodule

// ===== rtl/lts_checker.sv =====
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks for the lyric timestamp parser, bound to its top level.
// ----------------------------------------------------------------------------
module lts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         text_valid,
    input logic                         text_ready,
    input logic                         text_is_final,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         result_parse_ok,
    input logic [lts_pkg::MILLIS_W-1:0] result_total_millis
);
    import lts_pkg::*;

    // A failed parse reports no time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_parse_ok) |-> (result_total_millis == '0))
    else $error("lts: failed parse carries a nonzero total");

    // The total never exceeds two-digit minutes and seconds plus 999 ms.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_total_millis <= MILLIS_MAX))
    else $error("lts: total out of range");

    // A last byte followed by an open result channel yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_ready && text_is_final) ##1 result_ready |=> result_valid)
    else $error("lts: result missing after final byte");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
    else $error("lts: result dropped under stall");

endmodule

bind lyric_timestamp_parser lts_checker u_lts_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .text_valid          (text.valid),
    .text_ready          (text.ready),
    .text_is_final       (text.is_final),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_parse_ok     (result.parse_ok),
    .result_total_millis (result.total_millis)
);

// ===== tb/tb_lyric_timestamp_parser.sv =====
// ----------------------------------------------------------------------------
// tb_lyric_timestamp_parser
// Streams timestamp text into the parser one byte per beat and checks each
// result against a byte-level model of the parser or a listed expectation,
// across several idling phases, a long result stall and full drains.
// ----------------------------------------------------------------------------
module tb_lyric_timestamp_parser;
    import lts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES     = 150;
    localparam int STUCK_LIMIT     = 2000;
    localparam int RESULT_LATENCY  = 4;
    localparam int END_CYCLES      = 10;
    localparam int BEATS_PER_PHASE = 380;
    localparam int REPORT_MAX      = 10;

    localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
    localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
    localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        SCAN_LEAD,
        SCAN_MIN,
        SCAN_MIN_GAP,
        SCAN_SEC_LEAD,
        SCAN_SEC,
        SCAN_SEC_GAP,
        SCAN_FRAC_LEAD,
        SCAN_FRAC,
        SCAN_FRAC_GAP,
        SCAN_BAD
    } scan_t;

    typedef struct packed {
        logic                ok;
        logic [MILLIS_W-1:0] ms;
    } stamp_t;

    typedef struct {
        string       text;
        bit          typed;
        logic        ok;
        int unsigned ms;
    } row_t;

    // Rows marked typed carry a result that is obvious from the text itself.
    row_t directed_rows[] = '{
        '{"0:0",                     1'b1, 1'b1, 0},
        '{"99:99.999",               1'b1, 1'b1, 6039999},
        '{"99:99.9999",              1'b0, 1'b0, 0},
        '{" \t12 . 34 : 5678 \n",    1'b0, 1'b0, 0},
        '{"7.8",                     1'b1, 1'b1, 428000},
        '{"5:75",                    1'b1, 1'b1, 375000},
        '{"1:2.5",                   1'b0, 1'b0, 0},
        '{"3:04.07",                 1'b0, 1'b0, 0},
        '{"0:0.0000",                1'b0, 1'b0, 0},
        '{"\n1\t:\t2\t.\t3\t",       1'b0, 1'b0, 0},
        '{"123:00",                  1'b1, 1'b0, 0},
        '{"1:234",                   1'b1, 1'b0, 0},
        '{"1:2.34567",               1'b1, 1'b0, 0},
        '{"1:2.",                    1'b1, 1'b0, 0},
        '{"1:2: ",                   1'b1, 1'b0, 0},
        '{"ab:cd",                   1'b1, 1'b0, 0},
        '{"1",                       1'b1, 1'b0, 0},
        '{"\t",                      1'b1, 1'b0, 0},
        '{"1 2:3",                   1'b1, 1'b0, 0},
        '{"1:2.3 4",                 1'b1, 1'b0, 0}
    };

    logic clk = 1'b0;
    logic rst_n;

    lts_text_if   text_ch ();
    lts_result_if res_ch ();

    lyric_timestamp_parser i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state of the parser.
    scan_t          scan_phase = SCAN_LEAD;
    logic [2:0]     run_len    = '0;
    logic [6:0]     mins_acc   = '0;
    logic [6:0]     secs_acc   = '0;
    logic [13:0]    frac_acc   = '0;

    stamp_t         pending_stamps[$];
    logic [TEXT_W-1:0] text_buf[$];

    // Side data that travels with each text beat.
    bit             beat_typed = 1'b0;
    stamp_t         beat_want  = '0;

    int             send_idle_pct  = 0;
    int             sink_stall_pct = 0;
    int             hold_requests  = 0;
    int             holds_served   = 0;
    int             hold_count     = 0;
    int             stuck_cycles   = 0;
    int             fail_count     = 0;
    int             beats_sent     = 0;
    int             strings_sent   = 0;
    int             stamps_good    = 0;
    int             stamps_bad     = 0;

    function automatic bit is_blank(input logic [TEXT_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [TEXT_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sep(input logic [TEXT_W-1:0] c);
        return c == CH_COLON || c == CH_DOT;
    endfunction

    task automatic note_failure(input string what, input stamp_t want, input stamp_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s: expected ok=%0b ms=%0d, got ok=%0b ms=%0d",
                     $time, what, want.ok, want.ms, got.ok, got.ms);
    endtask

    // Advances the model by one byte; on a final byte queues the timestamp.
    task automatic scan_byte(input logic [TEXT_W-1:0] c, input logic fin,
                             input bit typed, input stamp_t want);
        scan_t               nxt;
        logic [3:0]          d;
        logic [MILLIS_W-1:0] frac_ms;
        stamp_t              stamp;
        nxt = SCAN_BAD;
        d   = 4'(c - CH_ZERO);
        case (scan_phase)
            SCAN_LEAD:
            begin
                if (is_blank(c))
                    nxt = SCAN_LEAD;
                else if (is_digit(c))
                begin
                    mins_acc = 7'(d);
                    run_len  = 3'd1;
                    nxt      = SCAN_MIN;
                end
            end
            SCAN_MIN:
            begin
                if (is_digit(c) && run_len < 3'd2)
                begin
                    mins_acc = 7'(mins_acc * 10 + d);
                    run_len  = run_len + 3'd1;
                    nxt      = SCAN_MIN;
                end
                else if (is_blank(c))
                    nxt = SCAN_MIN_GAP;
                else if (is_sep(c))
                    nxt = SCAN_SEC_LEAD;
            end
            SCAN_MIN_GAP:
            begin
                if (is_blank(c))
                    nxt = SCAN_MIN_GAP;
                else if (is_sep(c))
                    nxt = SCAN_SEC_LEAD;
            end
            SCAN_SEC_LEAD:
            begin
                if (is_blank(c))
                    nxt = SCAN_SEC_LEAD;
                else if (is_digit(c))
                begin
                    secs_acc = 7'(d);
                    run_len  = 3'd1;
                    nxt      = SCAN_SEC;
                end
            end
            SCAN_SEC:
            begin
                if (is_digit(c) && run_len < 3'd2)
                begin
                    secs_acc = 7'(secs_acc * 10 + d);
                    run_len  = run_len + 3'd1;
                    nxt      = SCAN_SEC;
                end
                else if (is_blank(c))
                    nxt = SCAN_SEC_GAP;
                else if (is_sep(c))
                    nxt = SCAN_FRAC_LEAD;
            end
            SCAN_SEC_GAP:
            begin
                if (is_blank(c))
                    nxt = SCAN_SEC_GAP;
                else if (is_sep(c))
                    nxt = SCAN_FRAC_LEAD;
            end
            SCAN_FRAC_LEAD:
            begin
                if (is_blank(c))
                    nxt = SCAN_FRAC_LEAD;
                else if (is_digit(c))
                begin
                    frac_acc = 14'(d);
                    run_len  = 3'd1;
                    nxt      = SCAN_FRAC;
                end
            end
            SCAN_FRAC:
            begin
                if (is_digit(c) && run_len < 3'd4)
                begin
                    frac_acc = 14'(frac_acc * 10 + d);
                    run_len  = run_len + 3'd1;
                    nxt      = SCAN_FRAC;
                end
                else if (is_blank(c))
                    nxt = SCAN_FRAC_GAP;
            end
            SCAN_FRAC_GAP:
            begin
                if (is_blank(c))
                    nxt = SCAN_FRAC_GAP;
            end
            default:
                nxt = SCAN_BAD;
        endcase
        scan_phase = nxt;

        if (fin)
        begin
            stamp = '0;
            stamp.ok = scan_phase inside {SCAN_SEC, SCAN_SEC_GAP, SCAN_FRAC, SCAN_FRAC_GAP};
            if (stamp.ok)
            begin
                frac_ms = '0;
                if (scan_phase inside {SCAN_FRAC, SCAN_FRAC_GAP})
                begin
                    // The fraction is scaled to milliseconds by its digit count.
                    case (run_len)
                        3'd1:    frac_ms = MILLIS_W'(frac_acc * 100);
                        3'd2:    frac_ms = MILLIS_W'(frac_acc * 10);
                        3'd4:    frac_ms = MILLIS_W'(frac_acc / 10);
                        default: frac_ms = MILLIS_W'(frac_acc);
                    endcase
                end
                stamp.ms = MILLIS_W'(mins_acc * 60000 + secs_acc * 1000 + frac_ms);
            end
            pending_stamps = {pending_stamps, (typed ? want : stamp)};
            scan_phase = SCAN_LEAD;
            run_len    = '0;
            mins_acc   = '0;
            secs_acc   = '0;
            frac_acc   = '0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && text_ch.valid && text_ch.ready)
            scan_byte(text_ch.text_byte, text_ch.is_final, beat_typed, beat_want);
    end

    always @(posedge clk)
    begin
        stamp_t got;
        stamp_t want;
        bit     bad;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            got.ok = res_ch.parse_ok;
            got.ms = res_ch.total_millis;
            if (pending_stamps.size() == 0)
                note_failure("result with nothing pending", '0, got);
            else
            begin
                want = pending_stamps.pop_front();
                bad  = 1'b0;
                if (got.ok !== want.ok)
                    bad = 1'b1;
                if (got.ms !== want.ms)
                    bad = 1'b1;
                if (bad)
                    note_failure("result mismatch", want, got);
                if (want.ok)
                    stamps_good++;
                else
                    stamps_bad++;
            end
        end
    end

    // Result side: random stalls, plus a long counted hold-off on request.
    initial
        res_ch.ready = 1'b0;

    always @(posedge clk)
    begin
        if (holds_served < hold_requests)
        begin
            res_ch.ready <= 1'b0;
            if (hold_count == HOLD_CYCLES - 1)
            begin
                hold_count   <= 0;
                holds_served <= holds_served + 1;
            end
            else
                hold_count <= hold_count + 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_beat(input logic [TEXT_W-1:0] c, input logic fin,
                             input bit typed, input stamp_t want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= c;
        text_ch.is_final  <= fin;
        beat_typed        <= typed;
        beat_want         <= want;
        do
            @(posedge clk);
        while (!text_ch.ready);
        beats_sent++;
    endtask

    task automatic send_text_buf();
        int k;
        for (k = 0; k < text_buf.size(); k++)
            send_beat(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
        strings_sent++;
    endtask

    // Stops the sender until every pending result is out and the pipe is empty.
    task automatic drain();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic push_blanks();
        int n;
        int pick;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            pick = $urandom_range(5);
            text_buf = {text_buf, (pick == 5 ? CH_SPACE : TEXT_W'(CH_TAB + pick))};
        end
    endtask

    task automatic push_digits(input int n);
        int v;
        repeat (n)
        begin
            // Nines are favored so that the largest values come up often.
            v = ($urandom_range(7) == 0) ? 9 : $urandom_range(9);
            text_buf = {text_buf, TEXT_W'(CH_ZERO + v)};
        end
    endtask

    task automatic compose(input int min_n, input int sec_n, input int frac_n,
                           input bit trail_sep);
        text_buf.delete();
        push_blanks();
        push_digits(min_n);
        push_blanks();
        text_buf = {text_buf, ($urandom_range(1) ? CH_COLON : CH_DOT)};
        push_blanks();
        push_digits(sec_n);
        push_blanks();
        if (frac_n > 0 || trail_sep)
        begin
            text_buf = {text_buf, ($urandom_range(1) ? CH_COLON : CH_DOT)};
            push_blanks();
            push_digits(frac_n);
            push_blanks();
        end
    endtask

    task automatic compose_well_formed();
        compose($urandom_range(1, 2), $urandom_range(1, 2),
                ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4), 1'b0);
    endtask

    task automatic make_random_string();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 72)
            compose_well_formed();
        else if (kind < 88)
        begin
            case ($urandom_range(4))
                0:
                begin
                    // One digit run is a digit too long.
                    case ($urandom_range(2))
                        0: compose(3, $urandom_range(1, 2), $urandom_range(0, 4), 1'b0);
                        1: compose($urandom_range(1, 2), 3, $urandom_range(0, 4), 1'b0);
                        default: compose($urandom_range(1, 2), $urandom_range(1, 2), 5, 1'b0);
                    endcase
                end
                1:
                    compose($urandom_range(1, 2), $urandom_range(1, 2), 0, 1'b1);
                2:
                begin
                    compose_well_formed();
                    text_buf[$urandom_range(text_buf.size() - 1)] = TEXT_W'($urandom_range(255));
                end
                3:
                begin
                    compose_well_formed();
                    n = $urandom_range(1, text_buf.size());
                    while (text_buf.size() > n)
                        void'(text_buf.pop_back());
                end
                default:
                begin
                    compose_well_formed();
                    if (text_buf.size() > 1)
                        text_buf.delete($urandom_range(text_buf.size() - 1));
                end
            endcase
        end
        else
        begin
            text_buf.delete();
            n = $urandom_range(1, 6);
            repeat (n)
                text_buf = {text_buf, TEXT_W'($urandom_range(255))};
        end
    endtask

    initial
    begin
        int     send_pct_tbl[4];
        int     stall_pct_tbl[4];
        int     k;
        int     p;
        int     phase_beats;
        stamp_t want;

        send_pct_tbl      = '{0, 58, 0, 30};
        stall_pct_tbl     = '{0, 0, 58, 30};
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.is_final  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            want.ok = directed_rows[r].ok;
            want.ms = MILLIS_W'(directed_rows[r].ms);
            for (k = 0; k < directed_rows[r].text.len(); k++)
                send_beat(directed_rows[r].text[k], k == directed_rows[r].text.len() - 1,
                          directed_rows[r].typed, want);
            strings_sent++;
        end
        drain();

        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct_tbl[p];
            sink_stall_pct = stall_pct_tbl[p];
            // In the first phase the result side holds off while text keeps
            // coming, so the parser fills up and pushes back on its input.
            if (p == 0)
                hold_requests <= hold_requests + 1;
            phase_beats = 0;
            while (phase_beats < BEATS_PER_PHASE)
            begin
                make_random_string();
                phase_beats += text_buf.size();
                send_text_buf();
            end
            drain();
        end

        repeat (END_CYCLES) @(posedge clk);

        $display("Sent %0d timestamp strings in %0d text beats over four idling phases.",
                 strings_sent, beats_sent);
        $display("Checked %0d well formed and %0d rejected results, %0d failures.",
                 stamps_good, stamps_bad, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lyric_timestamp_parser.sv
rtl/lts_checker.sv
tb/tb_lyric_timestamp_parser.sv
